[rtl/core/smdd_pkg.sv]
`default_nettype none
package smdd_pkg;

  localparam int SAMPLE_W       = 24;
  localparam int DELAY_W        = 20;
  localparam int MIX_W          = 16;
  localparam int LINE_DEPTH_DEF = 4096;

  // LFO table size is fixed; the ROM is built at elaboration
  localparam int SINE_POINTS    = 256;
  localparam int QUARTER_POINTS = SINE_POINTS / 4;
  localparam int QIDX_W         = $clog2(QUARTER_POINTS + 1);
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  localparam logic [MIX_W-1:0] FULL_MIX = 16'h8000;

  // pipeline steps of one frame
  localparam int NSTG      = 7;
  localparam int STG_READ  = 4;
  localparam int STG_WRITE = 5;

  typedef enum logic [2:0] {
    REG_BASE_DELAY   = 3'd0,
    REG_MIN_DELAY    = 3'd1,
    REG_MOD_DEPTH    = 3'd2,
    REG_WIDTH_OFFSET = 3'd3,
    REG_PHASE_STEP   = 3'd4,
    REG_WET_MIX      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic              wrapped;  // every line entry written at least once
    logic [NSTG-1:1]   ld;       // step n is active this cycle
  } lane_ctl_t;

  // round(32768*sin(pi/2*k/Q)) via Q30 Taylor series, capped at 32767
  function automatic logic [14:0] sine_entry(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    x    = (PI_HALF_Q30 * longint'(k)) / QUARTER_POINTS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    if (sum < 0) sum = 0;
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767) v = 64'sd32767;
    return v[14:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/smdd_sine.sv]
`default_nettype none
module smdd_sine (
  input  wire logic [31:0]        phase,
  output logic signed [15:0]      sine
);
  import smdd_pkg::*;

  logic [14:0]             sine_tab [QUARTER_POINTS+1];
  logic [29+QIDX_W:0]      kprod;
  logic [QIDX_W-1:0]       k;
  logic [QIDX_W-1:0]       idx;
  logic [14:0]             mag;

  for (genvar g = 0; g <= QUARTER_POINTS; g++) begin : g_tab
    assign sine_tab[g] = sine_entry(g);
  end

  always_comb begin
    kprod = (30+QIDX_W)'(phase[29:0]) * (30+QIDX_W)'(QUARTER_POINTS);
    k     = kprod[29+QIDX_W:30];
    // odd quadrants run the table backwards
    idx   = phase[30] ? QIDX_W'(QUARTER_POINTS) - k : k;
    mag   = sine_tab[idx];
    sine  = phase[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule
`default_nettype wire

[rtl/core/smdd_lane.sv]
`default_nettype none
module smdd_lane #(
  parameter int LINE_DEPTH = smdd_pkg::LINE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire smdd_pkg::lane_ctl_t                 ctl,
  input  wire logic [31:0]                         phase,
  input  wire logic [smdd_pkg::DELAY_W-1:0]        extra,
  input  wire logic [smdd_pkg::DELAY_W-1:0]        base_delay,
  input  wire logic [smdd_pkg::DELAY_W-1:0]        min_delay,
  input  wire logic [smdd_pkg::DELAY_W-1:0]        mod_depth,
  input  wire logic [smdd_pkg::MIX_W-1:0]          wet_w,
  input  wire logic signed [smdd_pkg::SAMPLE_W-1:0] x,
  input  wire logic [$clog2(LINE_DEPTH)-1:0]       wp,
  output logic signed [smdd_pkg::SAMPLE_W-1:0]     result
);
  import smdd_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int DW = (AW + 9 > 23) ? AW + 9 : 23;
  localparam logic signed [DW-1:0] DMAX = DW'((LINE_DEPTH - 2) * 256);
  localparam logic [AW+8:0]        SPAN = (AW+9)'(LINE_DEPTH * 256);
  localparam logic signed [26:0]   SAT_MAX = 27'sd8388607;
  localparam logic signed [26:0]   SAT_MIN = -27'sd8388608;

  logic [SAMPLE_W-1:0] mem [LINE_DEPTH];

  logic signed [15:0]         sine;
  logic signed [15:0]         sine_r;
  logic signed [36:0]         swing_prod;
  logic signed [21:0]         swing_r;
  logic signed [DW-1:0]       dsum;
  logic signed [DW-1:0]       dlo;
  logic signed [DW-1:0]       dmin;
  logic signed [DW-1:0]       dcl;
  logic [AW+7:0]              d_r;
  logic [AW+8:0]              tdiff;
  logic [AW+8:0]              rp;
  logic [AW-1:0]              i0;
  logic [AW-1:0]              i1;
  logic [SAMPLE_W-1:0]        rd0_r;
  logic [SAMPLE_W-1:0]        rd1_r;
  logic                       ok0_r;
  logic                       ok1_r;
  logic [7:0]                 f_r;
  logic signed [SAMPLE_W-1:0] tap0;
  logic signed [SAMPLE_W-1:0] tap1;
  logic signed [34:0]         isum;
  logic signed [SAMPLE_W-1:0] wet_r;
  logic [MIX_W-1:0]           dry_w;
  logic signed [40:0]         pa_r;
  logic signed [40:0]         pb_r;
  logic signed [41:0]         msum;
  logic signed [26:0]         mix;

  smdd_sine u_sine (
    .phase (phase),
    .sine  (sine)
  );

  // step 2: swing = floor(depth * sine / 2^15)
  assign swing_prod = 37'($signed({1'b0, mod_depth})) * 37'(sine_r);

  // step 3: total delay and clamp (upper limit wins)
  always_comb begin
    dsum = $signed(DW'(base_delay) + DW'(extra)) + DW'(swing_r);
    dlo  = $signed(DW'(min_delay));
    dmin = (dsum < dlo) ? dlo : dsum;
    dcl  = (dmin > DMAX) ? DMAX : dmin;
  end

  // step 4: read position, wrapped into the line
  always_comb begin
    tdiff = {1'b0, wp, 8'h00} - {1'b0, d_r};
    rp    = tdiff[AW+8] ? tdiff + SPAN : tdiff;
    i0    = rp[AW+7:8];
    i1    = (i0 == AW'(LINE_DEPTH - 1)) ? '0 : i0 + 1'b1;
  end

  // step 5: linear interpolation; unwritten entries read as zero
  always_comb begin
    tap0 = ok0_r ? $signed(rd0_r) : '0;
    tap1 = ok1_r ? $signed(rd1_r) : '0;
    isum = 35'(tap0) * 35'($signed({1'b0, 9'd256 - {1'b0, f_r}}))
         + 35'(tap1) * 35'($signed({2'b00, f_r}));
  end

  assign dry_w = FULL_MIX - wet_w;

  // step 7: mix sum, floor, saturate
  always_comb begin
    msum = 42'(pa_r) + 42'(pb_r);
    mix  = msum[41:15];
    if (mix > SAT_MAX) begin
      result = SAT_MAX[SAMPLE_W-1:0];
    end else if (mix < SAT_MIN) begin
      result = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      result = mix[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) sine_r  <= sine;
    if (ctl.ld[2]) swing_r <= swing_prod[36:15];
    if (ctl.ld[3]) d_r     <= dcl[AW+7:0];
    if (ctl.ld[STG_READ]) begin
      f_r   <= rp[7:0];
      ok0_r <= ctl.wrapped || (i0 < wp);
      ok1_r <= ctl.wrapped || (i1 < wp);
    end
    if (ctl.ld[STG_WRITE]) wet_r <= isum[31:8];
    if (ctl.ld[6]) begin
      pa_r <= 41'(x) * 41'($signed({1'b0, dry_w}));
      pb_r <= 41'(wet_r) * 41'($signed({1'b0, wet_w}));
    end
  end

  // delay line: two reads in step 4, write in step 5
  always_ff @(posedge clk) begin
    if (ctl.ld[STG_READ]) begin
      rd0_r <= mem[i0];
      rd1_r <= mem[i1];
    end
    if (ctl.ld[STG_WRITE]) begin
      mem[wp] <= x;
    end
  end

endmodule
`default_nettype wire

[rtl/core/smdd_merge.sv]
`default_nettype none
module smdd_merge (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 done,
  input  wire logic signed [smdd_pkg::SAMPLE_W-1:0] left,
  input  wire logic signed [smdd_pkg::SAMPLE_W-1:0] right,
  input  wire logic                                 out_tready,
  output logic                                      out_tvalid,
  output logic [2*smdd_pkg::SAMPLE_W-1:0]           out_tdata,
  output logic                                      load
);
  import smdd_pkg::*;

  logic                      valid_r;
  logic                      valid_nxt;
  logic [2*SAMPLE_W-1:0]     data_r;

  assign load = done && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= {right, left};
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule
`default_nettype wire

[rtl/core/stereo_modulated_delay_doubler.sv]
// Stereo modulated-delay doubler.
// in_*  : one stereo frame per beat, Q1.23 samples.
// out_* : one mixed stereo frame per input beat, same order, saturated Q1.23.
// cfg_* : register bank, register i at byte address 4*i; write only while idle.
// A frame walks seven steps shared by both lanes: sine lookup, depth multiply,
// delay clamp, delay-line read (two ports per lane), interpolation plus
// delay-line write, mix multiply, mix sum and saturate.
// A frame's result reaches out_tvalid after all seven steps, through the
// output register once it is free. Only one frame is in the chain at a
// time; a new frame is taken in the cycle the last step drains.
// The output register holds one finished frame, so when the receiver stalls
// the next frame still runs through the first six steps and waits at the
// last one; in_tready stays low until that frame can move out.
// Reset: registers return to their defaults, LFO phase and write pointer go
// to zero. The delay lines are not swept; entries not yet written since reset
// read as zero (tracked by the write pointer and a wrap flag), so the block
// is ready in the first cycle after reset.
`default_nettype none
module stereo_modulated_delay_doubler #(
  parameter int LINE_DEPTH = smdd_pkg::LINE_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // in_tdata: [23:0] left_in, [47:24] right_in
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [2*smdd_pkg::SAMPLE_W-1:0]      in_tdata,
  // out_tdata: [23:0] left_out, [47:24] right_out
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [2*smdd_pkg::SAMPLE_W-1:0]           out_tdata,
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [4:0]                           cfg_paddr,
  input  wire logic [31:0]                          cfg_pwdata,
  output logic [31:0]                               cfg_prdata,
  output logic                                      cfg_pready
);
  import smdd_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);

  // register bank
  logic [DELAY_W-1:0] base_delay_r;
  logic [DELAY_W-1:0] min_delay_r;
  logic [DELAY_W-1:0] mod_depth_r;
  logic [DELAY_W-1:0] width_offset_r;
  logic [31:0]        phase_step_r;
  logic [MIX_W-1:0]   wet_mix_r;
  reg_idx_t           cfg_idx;
  logic               cfg_wr;

  // frame state
  logic [31:0]          phase_r;
  logic [AW-1:0]        wp_r;
  logic                 wrapped_r;
  logic signed [SAMPLE_W-1:0] xl_r;
  logic signed [SAMPLE_W-1:0] xr_r;
  logic [NSTG:1]        v_r;
  logic [NSTG:1]        v_nxt;

  logic                 in_acc;
  logic                 out_load;
  logic [MIX_W-1:0]     wet_w;
  lane_ctl_t            ctl;
  logic signed [SAMPLE_W-1:0] left_res;
  logic signed [SAMPLE_W-1:0] right_res;

  // ---- configuration port ----
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_delay_r   <= 20'd245760;
      min_delay_r    <= 20'd12288;
      mod_depth_r    <= 20'd9830;
      width_offset_r <= 20'd51610;
      phase_step_r   <= 32'd26844;
      wet_mix_r      <= 16'd16384;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BASE_DELAY:   base_delay_r   <= cfg_pwdata[DELAY_W-1:0];
        REG_MIN_DELAY:    min_delay_r    <= cfg_pwdata[DELAY_W-1:0];
        REG_MOD_DEPTH:    mod_depth_r    <= cfg_pwdata[DELAY_W-1:0];
        REG_WIDTH_OFFSET: width_offset_r <= cfg_pwdata[DELAY_W-1:0];
        REG_PHASE_STEP:   phase_step_r   <= cfg_pwdata;
        REG_WET_MIX:      wet_mix_r      <= cfg_pwdata[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BASE_DELAY:   cfg_prdata = 32'(base_delay_r);
      REG_MIN_DELAY:    cfg_prdata = 32'(min_delay_r);
      REG_MOD_DEPTH:    cfg_prdata = 32'(mod_depth_r);
      REG_WIDTH_OFFSET: cfg_prdata = 32'(width_offset_r);
      REG_PHASE_STEP:   cfg_prdata = phase_step_r;
      REG_WET_MIX:      cfg_prdata = 32'(wet_mix_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // mix above full acts as fully wet
  assign wet_w = (wet_mix_r > FULL_MIX) ? FULL_MIX : wet_mix_r;

  // ---- step sequencing: one frame in flight ----
  assign in_tready = !(|v_r[NSTG-1:1]) && !(v_r[NSTG] && !out_load);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    v_nxt       = {v_r[NSTG-1:1], in_acc};
    // last step waits for the output register
    v_nxt[NSTG] = v_r[NSTG-1] || (v_r[NSTG] && !out_load);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      phase_r   <= '0;
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
      if (in_acc) phase_r <= phase_r + phase_step_r;
      // pointer moves once the frame has been written
      if (v_r[STG_WRITE]) begin
        if (wp_r == AW'(LINE_DEPTH - 1)) begin
          wp_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wp_r <= wp_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      xl_r <= in_tdata[SAMPLE_W-1:0];
      xr_r <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
  end

  assign ctl.wrapped = wrapped_r;
  assign ctl.ld      = v_r[NSTG-1:1];

  // ---- lanes ----
  smdd_lane #(.LINE_DEPTH(LINE_DEPTH)) u_lane_l (
    .clk        (clk),
    .ctl        (ctl),
    .phase      (phase_r),
    .extra      ('0),
    .base_delay (base_delay_r),
    .min_delay  (min_delay_r),
    .mod_depth  (mod_depth_r),
    .wet_w      (wet_w),
    .x          (xl_r),
    .wp         (wp_r),
    .result     (left_res)
  );

  // right lane: LFO a quarter turn ahead plus width offset
  smdd_lane #(.LINE_DEPTH(LINE_DEPTH)) u_lane_r (
    .clk        (clk),
    .ctl        (ctl),
    .phase      (phase_r + 32'h4000_0000),
    .extra      (width_offset_r),
    .base_delay (base_delay_r),
    .min_delay  (min_delay_r),
    .mod_depth  (mod_depth_r),
    .wet_w      (wet_w),
    .x          (xr_r),
    .wp         (wp_r),
    .result     (right_res)
  );

  // ---- merge into the output register ----
  smdd_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .done       (v_r[NSTG]),
    .left       (left_res),
    .right      (right_res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .load       (out_load)
  );

  // ---- assertions ----
  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(v_r))
    else $error("more than one frame in flight");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (v_r == NSTG'(1)))
    else $error("accepted beat did not start at the first step");

  a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[STG_WRITE] |=> (wp_r != $past(wp_r)))
    else $error("write pointer did not advance after the write step");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(v_r[NSTG]))
    else $error("output beat without a finished frame");

endmodule
`default_nettype wire

[tb/tb_stereo_modulated_delay_doubler.sv]
`default_nettype none
module tb_stereo_modulated_delay_doubler;
  timeunit 1ns;
  timeprecision 1ps;

  import smdd_pkg::*;

  localparam int          DEPTH     = LINE_DEPTH_DEF;
  localparam longint      SPAN      = longint'(DEPTH) * 256;
  localparam longint      DELAY_MAX = longint'(DEPTH - 2) * 256;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // Software view of the doubler: register copies, LFO phase, write pointer
  // and both delay lines. Every accepted input beat is mixed here right away
  // and the result waits in order for the matching output beat.
  class doubler_scoreboard;
    logic [19:0] base_delay;
    logic [19:0] min_delay;
    logic [19:0] mod_depth;
    logic [19:0] width_offset;
    logic [31:0] phase_step;
    logic [15:0] wet_mix;

    logic [31:0]        lfo_phase;
    int                 write_ptr;
    logic signed [23:0] left_line[DEPTH];
    logic signed [23:0] right_line[DEPTH];
    int                 sine_rom[QUARTER_POINTS + 1];
    logic [47:0]        pending_mixes[$];

    function new();
      base_delay   = 20'd245760;
      min_delay    = 20'd12288;
      mod_depth    = 20'd9830;
      width_offset = 20'd51610;
      phase_step   = 32'd26844;
      wet_mix      = 16'd16384;
      lfo_phase    = '0;
      write_ptr    = 0;
      for (int i = 0; i < DEPTH; i++) begin
        left_line[i]  = '0;
        right_line[i] = '0;
      end
      build_sine();
    endfunction

    // quarter-wave table, Q30 Taylor series rounded to Q15
    function void build_sine();
      longint unsigned x, x2, term;
      longint          sum, v;
      for (int k = 0; k <= QUARTER_POINTS; k++) begin
        x    = (PI_HALF_Q30 * longint'(k)) / QUARTER_POINTS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
          term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) sum = sum - longint'(term);
          else            sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        v = (sum + 16384) >>> 15;
        if (v > 32767) v = 32767;
        sine_rom[k] = int'(v);
      end
    endfunction

    function int sine_at(logic [31:0] phase);
      int k, s;
      k = int'((longint'(phase[29:0]) * QUARTER_POINTS) >> 30);
      if (k > QUARTER_POINTS) k = QUARTER_POINTS;
      s = phase[30] ? sine_rom[QUARTER_POINTS - k] : sine_rom[k];
      return phase[31] ? -s : s;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_BASE_DELAY:   base_delay   = value[19:0];
        REG_MIN_DELAY:    min_delay    = value[19:0];
        REG_MOD_DEPTH:    mod_depth    = value[19:0];
        REG_WIDTH_OFFSET: width_offset = value[19:0];
        REG_PHASE_STEP:   phase_step   = value;
        REG_WET_MIX:      wet_mix      = value[15:0];
        default: ;
      endcase
    endfunction

    // one channel: delay, clamp, interpolated read, write, mix
    function logic [23:0] mix_lane(bit lane_right, logic signed [23:0] x,
                                   logic [31:0] phase, logic [19:0] extra);
      longint             d, wet, mix;
      longint             rp;
      int                 i0, i1, f, w;
      logic signed [23:0] a, b;
      d = longint'(base_delay) + longint'(extra)
        + ((longint'(mod_depth) * longint'(sine_at(phase))) >>> 15);
      if (d < longint'(min_delay)) d = longint'(min_delay);
      if (d > DELAY_MAX)           d = DELAY_MAX;
      rp = (longint'(write_ptr) * 256 + SPAN - d) % SPAN;
      i0 = int'(rp >> 8);
      i1 = (i0 + 1) % DEPTH;
      f  = int'(rp & 255);
      a  = lane_right ? right_line[i0] : left_line[i0];
      b  = lane_right ? right_line[i1] : left_line[i1];
      wet = (longint'(a) * (256 - f) + longint'(b) * f) >>> 8;
      if (lane_right) right_line[write_ptr] = x;
      else            left_line[write_ptr]  = x;
      w = (wet_mix > 16'd32768) ? 32768 : int'(wet_mix);
      mix = (longint'(x) * (32768 - w) + wet * w) >>> 15;
      if (mix > 8388607)  mix = 8388607;
      if (mix < -8388608) mix = -8388608;
      return mix[23:0];
    endfunction

    function void mix_frame(logic [23:0] left, logic [23:0] right);
      logic [23:0] lo, ro;
      lfo_phase = lfo_phase + phase_step;
      lo = mix_lane(1'b0, left, lfo_phase, 20'd0);
      ro = mix_lane(1'b1, right, lfo_phase + QUARTER_TURN, width_offset);
      write_ptr = (write_ptr + 1) % DEPTH;
      pending_mixes.insert(pending_mixes.size(), {ro, lo});
    endfunction

    // returns 1 when the beat matches; otherwise why says what differs
    function bit check_frame(logic [47:0] got, output string why);
      logic [47:0] want;
      why = "";
      if (pending_mixes.size() == 0) begin
        why = $sformatf("output beat %h with no frame pending", got);
        return 1'b0;
      end
      want = pending_mixes.pop_front();
      if (got[23:0] !== want[23:0])
        why = $sformatf("left_out %0d, want %0d; ",
                        $signed(got[23:0]), $signed(want[23:0]));
      if (got[47:24] !== want[47:24])
        why = {why, $sformatf("right_out %0d, want %0d",
                              $signed(got[47:24]), $signed(want[47:24]))};
      return why == "";
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;    // [23:0] left_in, [47:24] right_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;        // [23:0] left_out, [47:24] right_out
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  doubler_scoreboard sb;
  int mismatches   = 0;
  int in_idle_pct  = 0;   // chance per beat of a sender gap
  int out_idle_pct = 0;   // chance per cycle of a receiver stall

  stereo_modulated_delay_doubler dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Outputs are sampled at the edge, before any update of that edge lands.
  always @(posedge clk) begin
    string why;
    if (rst_n && out_tvalid && out_tready) begin
      if (!sb.check_frame(out_tdata, why)) report_mismatch(why);
    end
  end

  // Receiver: ready high except for random stall bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // APB write: setup, then access; psel drops before the next transfer
  // so that it never touches psel twice in one step.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [19:0] base, input logic [19:0] lo_clamp,
                                input logic [19:0] depth, input logic [19:0] width,
                                input logic [31:0] step, input logic [15:0] wet);
    write_reg(REG_BASE_DELAY,   32'(base));
    write_reg(REG_MIN_DELAY,    32'(lo_clamp));
    write_reg(REG_MOD_DEPTH,    32'(depth));
    write_reg(REG_WIDTH_OFFSET, 32'(width));
    write_reg(REG_PHASE_STEP,   step);
    write_reg(REG_WET_MIX,      32'(wet));
  endtask

  // One frame beat; a gap burst may precede it.
  task automatic send_frame(input logic [23:0] left, input logic [23:0] right);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {right, left};
    do @(posedge clk); while (!in_tready);
    sb.mix_frame(left, right);
  endtask

  // Stop sending, let every pending frame come out, then some margin
  // for the pipeline before the registers are touched.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_mixes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'($urandom_range(0, 511)) - 24'd256;
      default: return 24'($urandom);
    endcase
  endfunction

  // delays lean short so reads mostly land on frames already written
  function automatic logic [19:0] pick_delay();
    case ($urandom_range(0, 7))
      0:       return 20'd0;
      1:       return 20'hFFFFF;
      2:       return 20'($urandom);
      default: return 20'($urandom_range(0, 40 * 256));
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 32'h0400_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_wet();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 40;
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: full-scale and sign-edge samples.
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'h000000, 24'hFFFFFF);
    send_frame(24'h555555, 24'hAAAAAA);

    // Half-sample delay: blends the previous frame with the not yet
    // written entry at the write pointer; fully wet.
    settle();
    apply_settings(20'd128, 20'd0, 20'd0, 20'd0, 32'd0, 16'h8000);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h123456, 24'hEDCBA9);
    send_frame(24'h800000, 24'h7FFFFF);

    // Longest delay: min clamp above the top limit, top limit wins;
    // wet mix above full acts as full.
    settle();
    apply_settings(20'hFFFFF, 20'hFFFFF, 20'd0, 20'hFFFFF, 32'd0, 16'hFFFF);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h000001, 24'hFFFFFF);
    send_frame(24'h3C3C3C, 24'hC3C3C3);

    // Quarter-turn steps walk every sine quadrant; the full depth swing
    // drives the delay negative, so the min clamp raises it.
    settle();
    apply_settings(20'd512, 20'd1536, 20'hFFFFF, 20'd0, QUARTER_TURN, 16'd24576);
    repeat (5) send_frame(pick_sample(), pick_sample());

    // Dry only, phase step that wraps every frame.
    settle();
    apply_settings(20'd300, 20'd0, 20'd700, 20'd90, 32'hFFFF_FFFF, 16'd0);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'h0F0F0F, 24'hF0F0F0);

    // Random phases: new register set, new idle mix each time.
    for (int p = 0; p < 7; p++) begin
      settle();
      apply_settings(pick_delay(), pick_delay(), pick_delay(), pick_delay(),
                     pick_step(), pick_wet());
      in_idle_pct  = pick_idle();
      out_idle_pct = pick_idle();
      repeat (100) send_frame(pick_sample(), pick_sample());
    end

    // Last part, no idling: short modulated delays just behind the
    // write pointer.
    settle();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    apply_settings(20'd845, 20'd0, 20'd512, 20'd1280, 32'h0100_0000, 16'd20000);
    repeat (100) send_frame(pick_sample(), pick_sample());

    // under one sample: entry at the write pointer is not yet written
    settle();
    apply_settings(20'd100, 20'd0, 20'd0, 20'd60, 32'd0, 16'h8000);
    repeat (40) send_frame(pick_sample(), pick_sample());

    // longest delay, reaching back past the oldest written entries
    settle();
    apply_settings(20'hFFFFF, 20'd0, 20'd4096, 20'd0, $urandom, 16'h7000);
    repeat (40) send_frame(pick_sample(), pick_sample());

    settle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #(64'd10_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
